>>> sv/bfa_pkg.sv
package bfa_pkg;

	localparam int ALLOC_ENTRIES_DEF = 64;
	localparam int ADDR_WIDTH_DEF = 16;

	localparam int STATUS_W = 3;
	localparam int COUNT_W = 7;

	localparam logic [STATUS_W-1:0] ST_OK = 3'd0;
	localparam logic [STATUS_W-1:0] ST_NO_FIT = 3'd1;
	localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NOT_ALLOCATED = 3'd3;
	localparam logic [STATUS_W-1:0] ST_ZERO_SIZE = 3'd4;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE = 1'b1;

endpackage

>>> sv/best_fit_allocator_coalescing_unit.sv
// allocate sweeps the used table, the free table, then both tables for the statistics; free
// sweeps the used table, the free table twice, then both; zero size, full table or unknown
// address sweep the used table, then both; every sweep reads one entry per cycle
// throughput: one request at a time; the next is accepted after the result is loaded
// reset: asynchronous, active low; the pool returns to one free extent of 65536 units
// a pool_size write reinitializes the tables; no request meanwhile
module best_fit_allocator_coalescing_unit #(
	parameter int ALLOC_ENTRIES = bfa_pkg::ALLOC_ENTRIES_DEF,
	parameter int ADDR_WIDTH = bfa_pkg::ADDR_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [16:0] cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	// request_size[16:0], block_address[32:17], zero pad
	input  logic [39:0] s_tdata,
	// operation
	input  logic        s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// status[2:0], result_address[18:3], result_size[35:19], free_count[42:36],
	// smallest_free[59:43], largest_free[76:60], used_count[83:77],
	// smallest_used[100:84], largest_used[117:101], zero pad
	output logic [119:0] m_tdata
);
	import bfa_pkg::*;

	localparam int FE = ALLOC_ENTRIES + 1;
	localparam int FIW = $clog2(FE);
	localparam int UIW = $clog2(ALLOC_ENTRIES);
	localparam int LW = ADDR_WIDTH + 1;
	localparam int AW = 16;
	localparam int SW = 17;
	localparam logic [LW-1:0] POOL_MAX = LW'(1) << ADDR_WIDTH;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_USCAN, S_FSCAN, S_FDEC, S_MERGE, S_SLOT, S_FWRITE,
		S_STATF, S_STATU, S_DONE
	} state_t;

	// free table: start and length in two memories written together, valid bits in flops
	logic [ADDR_WIDTH-1:0] fs_mem [FE];
	logic [LW-1:0]         fl_mem [FE];
	logic [FE-1:0]         fv_q;
	logic [ADDR_WIDTH-1:0] us_mem [ALLOC_ENTRIES];
	logic [LW-1:0]         ul_mem [ALLOC_ENTRIES];
	logic [ALLOC_ENTRIES-1:0] uv_q;

	state_t state_q;
	logic [FIW:0] idx_q;
	logic         rd_v_q;
	logic [FIW:0] rd_idx_q;
	logic [ADDR_WIDTH-1:0] fs_rd, us_rd;
	logic [LW-1:0] fl_rd, ul_rd;

	logic [LW-1:0] pool_q;
	logic op_q;
	logic [SW-1:0] req_q;
	logic [AW-1:0] addr_q;
	logic [STATUS_W-1:0] st_q;
	logic [ADDR_WIDTH-1:0] rstart_q;
	logic [LW-1:0] rlen_q;
	logic [ADDR_WIDTH:0] mstart_q, mend_q;
	logic best_v_q;
	logic [FIW-1:0] best_q;
	logic [ADDR_WIDTH-1:0] bs_q;
	logic [LW-1:0] bl_q;
	logic u_hit_q, u_slot_v_q;
	logic [UIW-1:0] u_hit_q_idx, u_slot_q;
	logic [COUNT_W-1:0] cnt_q;
	logic [LW-1:0] lo_q, hi_q;
	logic [COUNT_W-1:0] fc_q;
	logic [LW-1:0] flo_q, fhi_q;

	// memory write port controls
	logic f_we;
	logic [FIW-1:0] f_wa;
	logic [ADDR_WIDTH-1:0] f_ws;
	logic [LW-1:0] f_wl;
	logic u_we;
	logic [UIW-1:0] u_wa;

	logic [LW-1:0] cfg_eff;
	always_comb begin
		cfg_eff = (cfg_wdata == 17'd0) ? LW'(1) :
			((18'(cfg_wdata) > 18'(POOL_MAX)) ? POOL_MAX : LW'(cfg_wdata));
	end

	logic [FIW-1:0] ridx;
	logic [UIW-1:0] ruidx;
	assign ridx = idx_q[FIW-1:0];
	assign ruidx = idx_q[UIW-1:0];

	always_ff @(posedge clk) begin
		if (f_we) begin
			fs_mem[f_wa] <= f_ws;
			fl_mem[f_wa] <= f_wl;
		end
		if (u_we) begin
			us_mem[u_wa] <= bs_q;
			ul_mem[u_wa] <= LW'(req_q);
		end
		fs_rd <= fs_mem[ridx];
		fl_rd <= fl_mem[ridx];
		us_rd <= us_mem[ruidx];
		ul_rd <= ul_mem[ruidx];
	end

	logic last_f, last_u;
	assign last_f = (idx_q == (FIW+1)'(FE - 1));
	assign last_u = (idx_q == (FIW+1)'(ALLOC_ENTRIES - 1));
	logic rd_fv, rd_uv;
	assign rd_fv = fv_q[rd_idx_q[FIW-1:0]];
	assign rd_uv = uv_q[rd_idx_q[UIW-1:0]];

	always_comb begin
		f_we = 1'b0;
		f_wa = best_q;
		f_ws = bs_q;
		f_wl = bl_q;
		u_we = 1'b0;
		u_wa = u_slot_q;
		if (state_q == S_CLEAR && idx_q == '0) begin
			f_we = 1'b1;
			f_wa = '0;
			f_ws = '0;
			f_wl = pool_q;
		end else if (state_q == S_FDEC) begin
			u_we = best_v_q;
			f_we = best_v_q && (bl_q != LW'(req_q));
			f_ws = bs_q + ADDR_WIDTH'(req_q);
			f_wl = bl_q - LW'(req_q);
		end else if (state_q == S_FWRITE) begin
			f_we = best_v_q;
			f_ws = mstart_q[ADDR_WIDTH-1:0];
			f_wl = LW'(mend_q - mstart_q);
		end
	end

	logic rd_fit, rd_better;
	assign rd_fit = rd_fv && (18'(fl_rd) >= 18'(req_q));
	assign rd_better = !best_v_q || fl_rd < bl_q || (fl_rd == bl_q && fs_rd < bs_q);

	// used table match, including the entry read in the last sweep cycle
	logic u_match;
	logic [UIW-1:0] hit_idx;
	logic [ADDR_WIDTH-1:0] hit_start;
	logic [LW-1:0] hit_len;
	assign u_match = rd_v_q && rd_uv && op_q == OP_FREE &&
		({{(AW+1-ADDR_WIDTH){1'b0}}, us_rd} == (AW+1)'(addr_q));
	assign hit_idx = u_hit_q ? u_hit_q_idx : rd_idx_q[UIW-1:0];
	assign hit_start = u_hit_q ? rstart_q : us_rd;
	assign hit_len = u_hit_q ? rlen_q : ul_rd;

	logic st_f, st_v, st_last, st_end;
	logic [LW-1:0] st_len;
	assign st_f = (state_q == S_STATF);
	assign st_v = st_f ? rd_fv : rd_uv;
	assign st_len = st_f ? fl_rd : ul_rd;
	assign st_last = st_f ? last_f : last_u;
	assign st_end = rd_v_q && rd_idx_q == (st_f ? (FIW+1)'(FE - 1) :
		(FIW+1)'(ALLOC_ENTRIES - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			idx_q <= '0;
			rd_v_q <= 1'b0;
			pool_q <= POOL_MAX;
			fv_q <= '0;
			uv_q <= '0;
			m_tvalid <= 1'b0;
		end else begin
			rd_idx_q <= idx_q;
			if (m_tvalid && m_tready)
				m_tvalid <= 1'b0;
			if (cfg_we) begin
				pool_q <= cfg_eff;
				state_q <= S_CLEAR;
				idx_q <= '0;
				rd_v_q <= 1'b0;
			end else begin
				case (state_q)
					S_CLEAR: begin
						// valid bits are flops; one pass keeps the memory write simple
						fv_q <= FE'(1);
						uv_q <= '0;
						state_q <= S_IDLE;
					end
					S_IDLE: begin
						if (s_tvalid && s_tready) begin
							op_q <= s_tuser;
							req_q <= s_tdata[16:0];
							addr_q <= s_tdata[32:17];
							best_v_q <= 1'b0;
							u_hit_q <= 1'b0;
							u_slot_v_q <= 1'b0;
							st_q <= ST_OK;
							rstart_q <= '0;
							rlen_q <= '0;
							idx_q <= '0;
							state_q <= S_USCAN;
						end
					end
					S_USCAN: begin
						// find a free slot and the address match in the used table
						if (!uv_q[ruidx] && !u_slot_v_q) begin
							u_slot_v_q <= 1'b1;
							u_slot_q <= ruidx;
						end
						if (u_match && !u_hit_q) begin
							u_hit_q <= 1'b1;
							u_hit_q_idx <= rd_idx_q[UIW-1:0];
							rstart_q <= us_rd;
							rlen_q <= ul_rd;
						end
						if (rd_v_q && rd_idx_q == (FIW+1)'(ALLOC_ENTRIES - 1)) begin
							rd_v_q <= 1'b0;
							idx_q <= '0;
							if (op_q == OP_ALLOC) begin
								if (req_q == '0) begin
									st_q <= ST_ZERO_SIZE;
									state_q <= S_STATF;
								end else if (!u_slot_v_q && uv_q[ruidx]) begin
									st_q <= ST_TABLE_FULL;
									state_q <= S_STATF;
								end else begin
									state_q <= S_FSCAN;
								end
							end else if (u_hit_q || u_match) begin
								uv_q[hit_idx] <= 1'b0;
								mstart_q <= (ADDR_WIDTH+1)'(hit_start);
								mend_q <= (ADDR_WIDTH+1)'(hit_start) + (ADDR_WIDTH+1)'(hit_len);
								state_q <= S_MERGE;
							end else begin
								st_q <= ST_NOT_ALLOCATED;
								state_q <= S_STATF;
							end
						end else begin
							rd_v_q <= 1'b1;
							if (!last_u) idx_q <= idx_q + 1'b1;
						end
					end
					S_FSCAN: begin
						if (rd_v_q && rd_fit && rd_better) begin
							best_v_q <= 1'b1;
							best_q <= rd_idx_q[FIW-1:0];
							bs_q <= fs_rd;
							bl_q <= fl_rd;
						end
						if (rd_v_q && rd_idx_q == (FIW+1)'(FE - 1)) begin
							rd_v_q <= 1'b0;
							idx_q <= '0;
							state_q <= S_FDEC;
						end else begin
							rd_v_q <= 1'b1;
							if (!last_f) idx_q <= idx_q + 1'b1;
						end
					end
					S_FDEC: begin
						if (!best_v_q) begin
							st_q <= ST_NO_FIT;
						end else begin
							rstart_q <= bs_q;
							rlen_q <= LW'(req_q);
							uv_q[u_slot_q] <= 1'b1;
							if (bl_q == LW'(req_q)) fv_q[best_q] <= 1'b0;
						end
						state_q <= S_STATF;
					end
					S_MERGE: begin
						if (rd_v_q && rd_fv) begin
							if ((ADDR_WIDTH+1)'(fs_rd) + (ADDR_WIDTH+1)'(fl_rd) ==
								(ADDR_WIDTH+1)'(rstart_q)) begin
								mstart_q <= (ADDR_WIDTH+1)'(fs_rd);
								fv_q[rd_idx_q[FIW-1:0]] <= 1'b0;
							end else if ((ADDR_WIDTH+1)'(fs_rd) ==
								(ADDR_WIDTH+1)'(rstart_q) + (ADDR_WIDTH+1)'(rlen_q)) begin
								mend_q <= (ADDR_WIDTH+1)'(fs_rd) + (ADDR_WIDTH+1)'(fl_rd);
								fv_q[rd_idx_q[FIW-1:0]] <= 1'b0;
							end
						end
						if (rd_v_q && rd_idx_q == (FIW+1)'(FE - 1)) begin
							rd_v_q <= 1'b0;
							idx_q <= '0;
							state_q <= S_SLOT;
						end else begin
							rd_v_q <= 1'b1;
							if (!last_f) idx_q <= idx_q + 1'b1;
						end
					end
					S_SLOT: begin
						// lowest invalid free slot
						if (!fv_q[ridx] && !best_v_q) begin
							best_v_q <= 1'b1;
							best_q <= ridx;
						end
						if (last_f) begin
							idx_q <= '0;
							state_q <= S_FWRITE;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
					S_FWRITE: begin
						if (best_v_q) fv_q[best_q] <= 1'b1;
						state_q <= S_STATF;
					end
					S_STATF, S_STATU: begin
						if (st_end) begin
							rd_v_q <= 1'b0;
							idx_q <= '0;
							if (st_f) begin
								fc_q <= cnt_q + ((rd_fv) ? 1'b1 : 1'b0);
								flo_q <= (rd_fv && (cnt_q == '0 || fl_rd < lo_q)) ? fl_rd : lo_q;
								fhi_q <= (rd_fv && fl_rd > hi_q) ? fl_rd : hi_q;
								state_q <= S_STATU;
							end else begin
								state_q <= S_DONE;
								cnt_q <= cnt_q + ((rd_uv) ? 1'b1 : 1'b0);
								lo_q <= (rd_uv && (cnt_q == '0 || ul_rd < lo_q)) ? ul_rd : lo_q;
								hi_q <= (rd_uv && ul_rd > hi_q) ? ul_rd : hi_q;
							end
						end else begin
							rd_v_q <= 1'b1;
							if (!st_last) idx_q <= idx_q + 1'b1;
							if (!rd_v_q && idx_q == '0) begin
								cnt_q <= '0;
								lo_q <= '0;
								hi_q <= '0;
							end else if (rd_v_q && st_v) begin
								if (cnt_q == '0 || st_len < lo_q) lo_q <= st_len;
								if (st_len > hi_q) hi_q <= st_len;
								cnt_q <= cnt_q + 1'b1;
							end
						end
					end
					S_DONE: begin
						if (!m_tvalid) begin
							m_tvalid <= 1'b1;
							m_tdata <= {2'b00, SW'(hi_q), SW'(lo_q), cnt_q, SW'(fhi_q),
								SW'(flo_q), fc_q,
								(st_q == ST_OK) ? SW'(rlen_q) : SW'(0),
								(st_q == ST_OK) ? AW'(rstart_q) : AW'(0), st_q};
							state_q <= S_IDLE;
						end
					end
					default: state_q <= S_IDLE;
				endcase
			end
		end
	end

	assign s_tready = (state_q == S_IDLE) && !cfg_we;

`ifndef NO_ASSERTIONS
	a_one_entry_left: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (fv_q != '0 || uv_q != '0))
		else $error("both tables empty");
	a_out_only_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == S_DONE))
		else $error("result without done");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !s_tready)
		else $error("ready while busy");
`endif

endmodule

>>> tb/testbench.sv
module testbench;
	import bfa_pkg::*;

	typedef struct {
		logic [2:0]  status;
		logic [15:0] addr;
		logic [16:0] size;
		logic [6:0]  free_cnt;
		logic [16:0] free_min;
		logic [16:0] free_max;
		logic [6:0]  used_cnt;
		logic [16:0] used_min;
		logic [16:0] used_max;
	} alloc_result_t;

	localparam int USED_N = 64;
	localparam int FREE_N = USED_N + 1;
	localparam int POOL_MAX = 65536;
	localparam int IDLE_LIMIT = 20000;

	class alloc_scoreboard;
		int fstart[FREE_N];
		int flen[FREE_N];
		bit fvalid[FREE_N];
		int ustart[USED_N];
		int ulen[USED_N];
		bit uvalid[USED_N];
		alloc_result_t pending[$];
		int mismatches;
		int checked;
		int status_seen[5];

		function void reinit(int value);
			int sz;
			sz = value & 32'h1FFFF;
			if (sz == 0) sz = 1;
			if (sz > POOL_MAX) sz = POOL_MAX;
			for (int i = 0; i < FREE_N; i++) fvalid[i] = 0;
			for (int i = 0; i < USED_N; i++) uvalid[i] = 0;
			fstart[0] = 0;
			flen[0] = sz;
			fvalid[0] = 1;
		endfunction

		function bit pick_used(output int a);
			int n;
			int k;
			n = 0;
			for (int i = 0; i < USED_N; i++) if (uvalid[i]) n++;
			a = 0;
			if (n == 0) return 0;
			k = $urandom_range(n - 1);
			for (int i = 0; i < USED_N; i++) begin
				if (uvalid[i]) begin
					if (k == 0) begin
						a = ustart[i];
						return 1;
					end
					k--;
				end
			end
			return 0;
		endfunction

		function logic [2:0] do_alloc(int req, output int a, output int sz);
			int best;
			int u;
			best = -1;
			u = -1;
			a = 0;
			sz = 0;
			if (req == 0) return ST_ZERO_SIZE;
			for (int i = USED_N - 1; i >= 0; i--) if (!uvalid[i]) u = i;
			if (u < 0) return ST_TABLE_FULL;
			for (int i = 0; i < FREE_N; i++) begin
				if (!fvalid[i] || flen[i] < req) continue;
				if (best < 0 || flen[i] < flen[best] ||
						(flen[i] == flen[best] && fstart[i] < fstart[best]))
					best = i;
			end
			if (best < 0) return ST_NO_FIT;
			a = fstart[best];
			sz = req;
			ustart[u] = fstart[best];
			ulen[u] = req;
			uvalid[u] = 1;
			if (flen[best] == req) begin
				fvalid[best] = 0;
			end else begin
				fstart[best] += req;
				flen[best] -= req;
			end
			return ST_OK;
		endfunction

		function logic [2:0] do_free(int blk, output int a, output int sz);
			int u;
			int s;
			int lo;
			int hi;
			u = -1;
			s = -1;
			a = 0;
			sz = 0;
			for (int i = USED_N - 1; i >= 0; i--)
				if (uvalid[i] && ustart[i] == blk) u = i;
			if (u < 0) return ST_NOT_ALLOCATED;
			uvalid[u] = 0;
			a = ustart[u];
			sz = ulen[u];
			lo = ustart[u];
			hi = ustart[u] + ulen[u];
			// coalesce with neighbors on both sides
			for (int i = 0; i < FREE_N; i++) begin
				if (!fvalid[i]) continue;
				if (fstart[i] + flen[i] == ustart[u]) begin
					lo = fstart[i];
					fvalid[i] = 0;
				end else if (fstart[i] == ustart[u] + ulen[u]) begin
					hi = fstart[i] + flen[i];
					fvalid[i] = 0;
				end
			end
			for (int i = FREE_N - 1; i >= 0; i--) if (!fvalid[i]) s = i;
			if (s >= 0) begin
				fstart[s] = lo;
				flen[s] = hi - lo;
				fvalid[s] = 1;
			end
			return ST_OK;
		endfunction

		function void note(logic op, int req, int blk);
			alloc_result_t r;
			int a;
			int sz;
			int c;
			int mn;
			int mx;
			if (op == OP_ALLOC) r.status = do_alloc(req, a, sz);
			else r.status = do_free(blk, a, sz);
			status_seen[r.status]++;
			r.addr = 16'(a);
			r.size = 17'(sz);
			c = 0; mn = 0; mx = 0;
			for (int i = 0; i < FREE_N; i++) begin
				if (!fvalid[i]) continue;
				if (c == 0 || flen[i] < mn) mn = flen[i];
				if (flen[i] > mx) mx = flen[i];
				c++;
			end
			r.free_cnt = 7'(c); r.free_min = 17'(mn); r.free_max = 17'(mx);
			c = 0; mn = 0; mx = 0;
			for (int i = 0; i < USED_N; i++) begin
				if (!uvalid[i]) continue;
				if (c == 0 || ulen[i] < mn) mn = ulen[i];
				if (ulen[i] > mx) mx = ulen[i];
				c++;
			end
			r.used_cnt = 7'(c); r.used_min = 17'(mn); r.used_max = 17'(mx);
			pending.push_back(r);
		endfunction

		function void check(logic [119:0] d);
			alloc_result_t e;
			alloc_result_t g;
			g.status = d[2:0];
			g.addr = d[18:3];
			g.size = d[35:19];
			g.free_cnt = d[42:36];
			g.free_min = d[59:43];
			g.free_max = d[76:60];
			g.used_cnt = d[83:77];
			g.used_min = d[100:84];
			g.used_max = d[117:101];
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", d);
				return;
			end
			e = pending.pop_front();
			checked++;
			if (g.status !== e.status || g.addr !== e.addr || g.size !== e.size ||
					g.free_cnt !== e.free_cnt || g.free_min !== e.free_min ||
					g.free_max !== e.free_max || g.used_cnt !== e.used_cnt ||
					g.used_min !== e.used_min || g.used_max !== e.used_max) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("mismatch %0d: exp st=%0d a=%0d s=%0d f=%0d/%0d/%0d u=%0d/%0d/%0d",
						checked, e.status, e.addr, e.size, e.free_cnt, e.free_min,
						e.free_max, e.used_cnt, e.used_min, e.used_max);
					$display("            got st=%0d a=%0d s=%0d f=%0d/%0d/%0d u=%0d/%0d/%0d",
						g.status, g.addr, g.size, g.free_cnt, g.free_min,
						g.free_max, g.used_cnt, g.used_min, g.used_max);
				end
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [16:0] cfg_wdata = '0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [39:0] s_tdata = '0;
	logic s_tuser = 0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [119:0] m_tdata;

	alloc_scoreboard sb = new();
	bit quiet = 0;
	bit hold_off = 0;
	int idle_cycles = 0;
	int sent = 0;
	int pool_now = POOL_MAX;

	always #6 clk = ~clk;

	best_fit_allocator_coalescing_unit u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) sb.check(m_tdata);
			m_tready <= !hold_off && (quiet || $urandom_range(99) >= 17);
			if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout, %0d results outstanding", sb.pending.size());
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	task automatic send_request(logic op, int req, int blk);
		if (!quiet) begin
			while ($urandom_range(99) < 17) begin
				s_tvalid <= 0;
				@(posedge clk);
			end
		end
		s_tvalid <= 1;
		s_tuser <= op;
		s_tdata <= {7'b0, blk[15:0], req[16:0]};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note(op, req, blk);
		sent++;
	endtask

	task automatic drain();
		s_tvalid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (250) @(posedge clk);
	endtask

	task automatic write_pool(int value);
		drain();
		cfg_we <= 1;
		cfg_wdata <= value[16:0];
		@(posedge clk);
		cfg_we <= 0;
		sb.reinit(value);
		pool_now = sb.flen[0];
		// clearing pass of the tables
		repeat (100) @(posedge clk);
	endtask

	task automatic random_request();
		int r;
		int a;
		int req;
		int junk;
		r = $urandom_range(99);
		junk = $urandom_range(POOL_MAX);
		if (r < 55) begin
			r = $urandom_range(9);
			if (r < 7) req = $urandom_range(1, (pool_now / 16 > 1) ? pool_now / 16 : 1);
			else if (r < 9) req = $urandom_range(1, pool_now);
			else begin
				case ($urandom_range(3))
					0: req = 0;
					1: req = POOL_MAX;
					2: req = POOL_MAX - 1;
					default: req = $urandom_range(POOL_MAX);
				endcase
			end
			send_request(OP_ALLOC, req, $urandom_range(16'hFFFF));
		end else if (r < 90 && sb.pick_used(a)) begin
			send_request(OP_FREE, junk, a);
		end else begin
			send_request(OP_FREE, junk, $urandom_range(16'hFFFF));
		end
	endtask

	initial begin
		int pools[8];
		pools = '{300, 1, 17'h1FFFF, 0, 2000, 64, POOL_MAX, 0};
		pools[7] = $urandom_range(100, 5000);
		sb.reinit(POOL_MAX);
		repeat (2) @(posedge clk);
		arst_n <= 1;
		repeat (3) @(posedge clk);

		// reset pool of full size
		send_request(OP_ALLOC, 0, 0);
		send_request(OP_ALLOC, POOL_MAX, 16'hFFFF);
		send_request(OP_ALLOC, 1, 0);
		send_request(OP_FREE, 17'h1FFFF & POOL_MAX, 0);
		send_request(OP_FREE, 0, 16'hFFFF);
		send_request(OP_ALLOC, 10, 0);
		send_request(OP_ALLOC, 5, 0);
		send_request(OP_ALLOC, 10, 0);
		send_request(OP_ALLOC, 5, 0);
		send_request(OP_ALLOC, 65535 - 30, 0);
		// two equal holes, lowest start wins
		send_request(OP_FREE, 0, 15);
		send_request(OP_FREE, 0, 0);
		send_request(OP_ALLOC, 10, 0);
		send_request(OP_ALLOC, 4, 0);
		// free between two free neighbors merges three ways
		send_request(OP_FREE, 0, 4);
		send_request(OP_FREE, 0, 10);
		send_request(OP_FREE, 0, 25);
		send_request(OP_FREE, 0, 30);
		send_request(OP_FREE, 0, 0);
		send_request(OP_ALLOC, 65535, 0);
		send_request(OP_FREE, 0, 0);

		foreach (pools[p]) begin
			write_pool(pools[p]);
			if (p == 3) quiet = 1;
			if (p == 2) begin
				fork
					begin
						hold_off = 1;
						repeat (600) @(posedge clk);
						hold_off = 0;
					end
				join_none
			end
			for (int k = 0; k < 55; k++) random_request();
			quiet = 0;
		end
		drain();
		$display("%0d requests over %0d pool sizes; status ok/nofit/full/unalloc/zero = %0d/%0d/%0d/%0d/%0d",
			sent, 9, sb.status_seen[0], sb.status_seen[1], sb.status_seen[2],
			sb.status_seen[3], sb.status_seen[4]);
		$display("%0d results checked, %0d mismatches", sb.checked, sb.mismatches);
		if (sb.mismatches == 0 && sb.pending.size() == 0) $display("Regression PASS");
		else $display("Regression FAIL");
		$finish;
	end
endmodule

>>> best_fit_allocator_coalescing_unit.f
sv/bfa_pkg.sv
sv/best_fit_allocator_coalescing_unit.sv
tb/testbench.sv
